### design/mcobm_pkg.sv
// Package for the multicart outer-bank mapper: request and result types,
// request kinds, banking modes and the fixed masks used by the translation.
// No dependencies.
`default_nettype none

package mcobm_pkg;

  // Request kinds carried in the kind field.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_PRG   = 2'd1,
    KIND_CHR   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Banking modes held in bits 7:6 of outer register 0.
  localparam logic [1:0] MODE_HALF  = 2'b10;
  localparam logic [1:0] MODE_SMALL = 2'b11;

  // Fixed masks and bit positions.
  localparam logic [7:0] MASK_PRG_WIDE  = 8'h3F;
  localparam logic [7:0] MASK_PRG_HALF  = 8'h1F;
  localparam logic [7:0] MASK_PRG_SMALL = 8'h0F;
  localparam logic [7:0] MASK_CHR_SMALL = 8'h7F;
  localparam logic [7:0] MASK_CHR_WIDE  = 8'hFF;
  localparam logic [7:0] MASK_CHR_FIXED = 8'h0F;
  localparam logic [7:0] MASK_BIG_OR    = 8'h0E;
  localparam logic [7:0] BIT_LOCK       = 8'h80;
  localparam logic [7:0] BIT_BIG        = 8'h10;

  // Upper address nibble of the register window.
  localparam logic [3:0] WINDOW_NIBBLE = 4'h6;

  // One request as held in the input register.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  value;
    logic        ram_enabled;
  } item_t;

  // One result as held in the result register.
  typedef struct packed {
    logic [15:0] map_address;
    logic [10:0] prg_bank;
    logic [7:0]  chr_bank;
    logic        chr_whole_8k;
    logic        ram_write;
    logic [7:0]  ram_data;
    logic        reg_loaded;
  } result_t;

  // The four outer registers as seen by the translation logic.
  typedef struct packed {
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
    logic [7:0] r3;
  } outer_t;

  // Load of one outer register.
  typedef struct packed {
    logic       en;
    logic [1:0] idx;
    logic [7:0] data;
  } reg_wr_t;

endpackage

`default_nettype wire

### design/mcobm_if.sv
// Handshake interfaces for the request and result channels of the mapper.
// No dependencies.
`default_nettype none

interface mcobm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  value;
  logic        ram_enabled;

  modport source (output valid, kind, address, value, ram_enabled, input ready);
  modport sink   (input valid, kind, address, value, ram_enabled, output ready);
endinterface

interface mcobm_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] map_address;
  logic [10:0] prg_bank;
  logic [7:0]  chr_bank;
  logic        chr_whole_8k;
  logic        ram_write;
  logic [7:0]  ram_data;
  logic        reg_loaded;

  modport source (output valid, map_address, prg_bank, chr_bank, chr_whole_8k,
                  ram_write, ram_data, reg_loaded, input ready);
  modport sink   (input valid, map_address, prg_bank, chr_bank, chr_whole_8k,
                  ram_write, ram_data, reg_loaded, output ready);
endinterface

`default_nettype wire

### design/multicart_outer_bank_mapper.sv
// Top level of the multicart outer-bank mapper: input register, translation
// and result register. Depends on mcobm_pkg, mcobm_if, mcobm_regs, mcobm_xlate.
//
//   Channel  Dir  Carries
//   cmd      in   kind, address, value, ram_enabled
//   res      out  map_address, prg_bank, chr_bank, chr_whole_8k,
//                 ram_write, ram_data, reg_loaded
//
// A request accepted into the input register is translated and enters the result
// register, from which it is offered on res. One request is accepted per cycle
// while the result register can take it; the translation between the two
// registers is a single pass.
// Reset clears the outer registers and both valid flags.
// A stalled result holds the result register, and the input register then
// holds its request; cmd.ready drops only when both are full and the result
// is stalled.
`default_nettype none

module multicart_outer_bank_mapper
  import mcobm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  mcobm_req_if.sink   cmd,
  mcobm_res_if.source res
);

  item_t   item;
  logic    item_valid;
  result_t result;
  logic    result_valid;
  result_t xl_res;
  reg_wr_t xl_wr;
  reg_wr_t reg_wr;
  outer_t  outer;
  logic    result_load;
  logic    item_load;

  // Flow control: the result register takes a request when empty or drained.
  assign result_load = item_valid && (!result_valid || res.ready);
  assign cmd.ready   = !item_valid || result_load;
  assign item_load   = cmd.valid && cmd.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item.kind        <= cmd.kind;
      item.address     <= cmd.address;
      item.value       <= cmd.value;
      item.ram_enabled <= cmd.ram_enabled;
    end
  end

  mcobm_xlate u_xlate (
    .item  (item),
    .outer (outer),
    .res   (xl_res),
    .wr    (xl_wr)
  );

  // Registers change only when the request moves into the result register.
  always_comb begin
    reg_wr    = xl_wr;
    reg_wr.en = xl_wr.en && result_load;
  end

  mcobm_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr    (reg_wr),
    .outer (outer)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (res.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= xl_res;
    end
  end

  assign res.valid        = result_valid;
  assign res.map_address  = result.map_address;
  assign res.prg_bank     = result.prg_bank;
  assign res.chr_bank     = result.chr_bank;
  assign res.chr_whole_8k = result.chr_whole_8k;
  assign res.ram_write    = result.ram_write;
  assign res.ram_data     = result.ram_data;
  assign res.reg_loaded   = result.reg_loaded;

endmodule

`default_nettype wire

### design/mcobm_regs.sv
// Outer register file of the mapper: four 8-bit registers, cleared at reset.
// Depends on mcobm_pkg.
`default_nettype none

module mcobm_regs
  import mcobm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire reg_wr_t wr,
  output outer_t       outer
);

  logic [7:0] regs [4];

  // Load one register per accepted window write that is a register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= '0;
      regs[1] <= '0;
      regs[2] <= '0;
      regs[3] <= '0;
    end else if (wr.en) begin
      regs[wr.idx] <= wr.data;
    end
  end

  assign outer.r0 = regs[0];
  assign outer.r1 = regs[1];
  assign outer.r2 = regs[2];
  assign outer.r3 = regs[3];

endmodule

`default_nettype wire

### design/mcobm_xlate.sv
// Translation logic of the mapper: turns one registered request and the
// current outer registers into a result and a register load.
// Depends on mcobm_pkg.
`default_nettype none

module mcobm_xlate
  import mcobm_pkg::*;
(
  input  wire item_t  item,
  input  wire outer_t outer,
  output result_t     res,
  output reg_wr_t     wr
);

  logic [1:0]  mode;
  logic        big;
  logic        locked;
  logic        in_window;
  logic [7:0]  base;
  logic [7:0]  prg_mask;
  logic [7:0]  big_bits;
  logic [11:0] prg_full;

  assign mode      = outer.r0[7:6];
  assign big       = (outer.r3 & BIT_BIG) != 8'h00;
  assign locked    = (outer.r3 & BIT_LOCK) != 8'h00;
  assign in_window = item.address[15:12] == WINDOW_NIBBLE;

  // Scrambled outer base from registers 0 and 1.
  assign base = {outer.r0[5:4], outer.r1[3:2], outer.r1[4], outer.r0[2:0]};

  // Inner bank mask by mode; mode 1 behaves as mode 0.
  always_comb begin
    case (mode)
      MODE_HALF:  prg_mask = MASK_PRG_HALF;
      MODE_SMALL: prg_mask = big ? {6'b0, outer.r1[1], 1'b1} : MASK_PRG_SMALL;
      default:    prg_mask = MASK_PRG_WIDE;
    endcase
  end

  // Extra bank bits from register 3 in the large mode.
  assign big_bits = big ? (outer.r3 & (MASK_BIG_OR ^ {6'b0, outer.r1[1], 1'b0})) : 8'h00;
  assign prg_full = {base, 4'b0} | {4'b0, item.value & prg_mask} | {4'b0, big_bits};

  // Result and register load by request kind.
  always_comb begin
    res             = '0;
    wr              = '0;
    res.map_address = item.address;
    case (item.kind)
      KIND_WRITE: begin
        if (in_window) begin
          if (item.ram_enabled) begin
            res.ram_write = 1'b1;
            res.ram_data  = item.value;
          end else if (!locked) begin
            wr.en          = 1'b1;
            wr.idx         = item.address[1:0];
            wr.data        = item.value;
            res.reg_loaded = 1'b1;
          end
        end
      end
      KIND_PRG: begin
        res.prg_bank = prg_full[10:0];
      end
      KIND_CHR: begin
        if (big) begin
          res.chr_bank     = outer.r2 & MASK_CHR_FIXED;
          res.chr_whole_8k = 1'b1;
        end else begin
          res.chr_bank = item.value &
                         ((mode == MODE_SMALL) ? MASK_CHR_SMALL : MASK_CHR_WIDE);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### design/mcobm_checker.sv
// Port-level checks for the multicart outer-bank mapper, bound to the top.
// Depends on multicart_outer_bank_mapper.
`default_nettype none

module mcobm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [7:0]  chr_bank,
  input wire logic        chr_whole_8k,
  input wire logic        ram_write,
  input wire logic [7:0]  ram_data,
  input wire logic        reg_loaded,
  input wire logic [10:0] prg_bank
);

  // A stalled result stays offered.
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its bank.
  a_bank_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(prg_bank) && $stable(chr_bank))
    else $error("result changed while stalled");

  // A window write goes either to RAM or to a register, never both.
  a_write_route: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(ram_write && reg_loaded))
    else $error("write routed to RAM and register");

  // RAM data only accompanies a RAM write.
  a_ram_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !ram_write |-> ram_data == 8'h00)
    else $error("RAM data without RAM write");

  // The fixed 8K CHR bank has only four bits.
  a_chr_fixed: assert property (@(posedge clk) disable iff (rst)
    res_valid && chr_whole_8k |-> chr_bank[7:4] == 4'h0 && !ram_write && !reg_loaded)
    else $error("fixed CHR bank out of range");

endmodule

bind multicart_outer_bank_mapper mcobm_checker u_mcobm_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .chr_bank     (res.chr_bank),
  .chr_whole_8k (res.chr_whole_8k),
  .ram_write    (res.ram_write),
  .ram_data     (res.ram_data),
  .reg_loaded   (res.reg_loaded),
  .prg_bank     (res.prg_bank)
);

`default_nettype wire

### tb/sv/multicart_outer_bank_mapper_tb.sv
// Self-checking testbench for the multicart outer-bank mapper.
// It drives requests through mcobm_req_if and predicts each result in a small scoreboard.
// It checks the results on mcobm_res_if. Depends on mcobm_pkg, mcobm_if and the mapper RTL.

module multicart_outer_bank_mapper_tb;
  import mcobm_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int LOCKED_REQUESTS = 60;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 250000;

  // Keeps its own copy of the outer registers and the queue of predicted mappings.
  class bank_map_scoreboard;
    logic [7:0] outer [4];
    result_t    pending_maps [$];
    int         failures;

    function new();
      foreach (outer[i]) outer[i] = 8'h00;
      failures = 0;
    endfunction

    // Works out the mapping of one request and applies any register load.
    function result_t map_request(item_t rq);
      result_t     exp;
      logic [7:0]  base;
      logic [7:0]  mask;
      logic [11:0] wide;
      logic        big;
      exp = '0;
      exp.map_address = rq.address;
      big  = (outer[3] & BIT_BIG) != 8'h00;
      base = {outer[0][5:4], outer[1][3:2], outer[1][4], outer[0][2:0]};
      case (kind_t'(rq.kind))
        KIND_WRITE: begin
          // Only the 0x6000 window is decoded; RAM takes priority over the registers.
          if (rq.address[15:12] == WINDOW_NIBBLE) begin
            if (rq.ram_enabled) begin
              exp.ram_write = 1'b1;
              exp.ram_data  = rq.value;
            end else if ((outer[3] & BIT_LOCK) == 8'h00) begin
              outer[rq.address[1:0]] = rq.value;
              exp.reg_loaded = 1'b1;
            end
          end
        end
        KIND_PRG: begin
          // Modes 0 and 1 share the wide mask.
          case (outer[0][7:6])
            MODE_HALF:  mask = MASK_PRG_HALF;
            MODE_SMALL: mask = big ? (8'h01 | (outer[1] & 8'h02)) : MASK_PRG_SMALL;
            default:    mask = MASK_PRG_WIDE;
          endcase
          wide = {base, 4'h0} | {4'h0, rq.value & mask};
          if (big) wide = wide | {4'h0, outer[3] & (MASK_BIG_OR ^ (outer[1] & 8'h02))};
          // The top bit of a wide bank is dropped.
          exp.prg_bank = wide[10:0];
        end
        KIND_CHR: begin
          if (big) begin
            exp.chr_bank     = outer[2] & MASK_CHR_FIXED;
            exp.chr_whole_8k = 1'b1;
          end else begin
            exp.chr_bank = rq.value &
                           ((outer[0][7:6] == MODE_SMALL) ? MASK_CHR_SMALL : MASK_CHR_WIDE);
          end
        end
        default: ;
      endcase
      return exp;
    endfunction

    function void note_request(item_t rq);
      pending_maps.push_back(map_request(rq));
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      failures++;
      $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    // Compares one result with the oldest prediction.
    task check_result(result_t got);
      result_t exp;
      if (pending_maps.size() == 0) begin
        report_mismatch("unexpected result, map_address", got.map_address, 0);
      end else begin
        exp = pending_maps.pop_front();
        if (got.map_address !== exp.map_address)
          report_mismatch("map_address", got.map_address, exp.map_address);
        if (got.prg_bank !== exp.prg_bank)
          report_mismatch("prg_bank", got.prg_bank, exp.prg_bank);
        if (got.chr_bank !== exp.chr_bank)
          report_mismatch("chr_bank", got.chr_bank, exp.chr_bank);
        if (got.chr_whole_8k !== exp.chr_whole_8k)
          report_mismatch("chr_whole_8k", got.chr_whole_8k, exp.chr_whole_8k);
        if (got.ram_write !== exp.ram_write)
          report_mismatch("ram_write", got.ram_write, exp.ram_write);
        if (got.ram_data !== exp.ram_data)
          report_mismatch("ram_data", got.ram_data, exp.ram_data);
        if (got.reg_loaded !== exp.reg_loaded)
          report_mismatch("reg_loaded", got.reg_loaded, exp.reg_loaded);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   send_burst = 0;
  int   recv_burst = 0;
  int   recv_hold = 0;

  bank_map_scoreboard bank_maps;

  mcobm_req_if cmd_if ();
  mcobm_res_if res_if ();

  multicart_outer_bank_mapper u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle cycles before the next request or result, with occasional runs of back-to-back traffic.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Offers one request and waits for it to be accepted.
  task automatic send_request(item_t rq);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.kind        <= rq.kind;
    cmd_if.address     <= rq.address;
    cmd_if.value       <= rq.value;
    cmd_if.ram_enabled <= rq.ram_enabled;
    do @(posedge clk); while (!cmd_if.ready);
    bank_maps.note_request(rq);
  endtask

  task automatic send_fields(kind_t k, logic [15:0] addr, logic [7:0] val, logic ram_en);
    item_t rq;
    rq.kind        = k;
    rq.address     = addr;
    rq.value       = val;
    rq.ram_enabled = ram_en;
    send_request(rq);
  endtask

  // Stops offering requests until every predicted result has come back.
  task automatic wait_all_mapped();
    cmd_if.valid <= 1'b0;
    while (bank_maps.pending_maps.size() != 0) @(posedge clk);
  endtask

  // Register and RAM writes, mostly in the window, translations and the odd stray request.
  function automatic item_t random_request(bit may_lock);
    item_t rq;
    int    pick;
    pick           = $urandom_range(0, 99);
    rq.address     = 16'($urandom);
    rq.value       = 8'($urandom);
    rq.ram_enabled = ($urandom_range(0, 3) == 0);
    if (pick < 40) begin
      rq.kind = KIND_WRITE;
      if (pick < 36) begin
        rq.address[15:12] = WINDOW_NIBBLE;
      end else if (rq.address[15:12] == WINDOW_NIBBLE) begin
        rq.address[12] = ~rq.address[12];
      end
      // Keep the lock clear until the locked part at the end.
      if (!may_lock && !rq.ram_enabled && rq.address[1:0] == 2'd3)
        rq.value[7] = 1'b0;
    end else if (pick < 70) begin
      rq.kind = KIND_PRG;
    end else if (pick < 96) begin
      rq.kind = KIND_CHR;
    end else begin
      rq.kind = KIND_NONE;
    end
    return rq;
  endfunction

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    result_t got;
    int      stall;
    res_if.ready = 1'b0;
    wait (!rst);
    forever begin
      if (recv_hold > 0) begin
        stall     = recv_hold;
        recv_hold = 0;
      end else begin
        stall = draw_gap(recv_burst);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got.map_address  = res_if.map_address;
      got.prg_bank     = res_if.prg_bank;
      got.chr_bank     = res_if.chr_bank;
      got.chr_whole_8k = res_if.chr_whole_8k;
      got.ram_write    = res_if.ram_write;
      got.ram_data     = res_if.ram_data;
      got.reg_loaded   = res_if.reg_loaded;
      bank_maps.check_result(got);
    end
  end

  // Request side and end of run.
  initial begin
    bank_maps = new();
    cmd_if.valid       = 1'b0;
    cmd_if.kind        = KIND_NONE;
    cmd_if.address     = 16'h0000;
    cmd_if.value       = 8'h00;
    cmd_if.ram_enabled = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Translations straight after reset, then the stray request kind.
    send_fields(KIND_PRG, 16'hFFFF, 8'hFF, 1'b1);
    send_fields(KIND_CHR, 16'h0000, 8'hFF, 1'b0);
    send_fields(KIND_NONE, 16'hFFFF, 8'hFF, 1'b1);
    // Writes just outside the window are ignored.
    send_fields(KIND_WRITE, 16'h5FFF, 8'hAA, 1'b0);
    send_fields(KIND_WRITE, 16'h7000, 8'h55, 1'b0);
    // Work RAM writes at both ends of the window.
    send_fields(KIND_WRITE, 16'h6000, 8'hFF, 1'b1);
    send_fields(KIND_WRITE, 16'h6FFF, 8'h00, 1'b1);
    // All ones in r0 and r1: small mode and a bank too wide for the field.
    send_fields(KIND_WRITE, 16'h6000, 8'hFF, 1'b0);
    send_fields(KIND_WRITE, 16'h6001, 8'hFF, 1'b0);
    send_fields(KIND_PRG, 16'h8000, 8'hFF, 1'b0);
    send_fields(KIND_CHR, 16'h1C00, 8'hFF, 1'b0);
    // Big mode through r3 bit 4, with a fixed 8K CHR bank from r2.
    send_fields(KIND_WRITE, 16'h6FFE, 8'hA5, 1'b0);
    send_fields(KIND_WRITE, 16'h6FFF, 8'h1E, 1'b0);
    send_fields(KIND_PRG, 16'hE000, 8'hFF, 1'b0);
    send_fields(KIND_CHR, 16'h0400, 8'h3C, 1'b0);
    // The mode that is left unset, then half mode.
    send_fields(KIND_WRITE, 16'h6004, 8'h40, 1'b0);
    send_fields(KIND_PRG, 16'hA000, 8'hFF, 1'b0);
    send_fields(KIND_WRITE, 16'h6008, 8'h80, 1'b0);
    send_fields(KIND_PRG, 16'hC000, 8'hFF, 1'b0);
    send_fields(KIND_CHR, 16'h0800, 8'hFF, 1'b0);
    // Back to zero in r0, r1 and r3.
    send_fields(KIND_WRITE, 16'h6000, 8'h00, 1'b0);
    send_fields(KIND_WRITE, 16'h6001, 8'h00, 1'b0);
    send_fields(KIND_WRITE, 16'h6003, 8'h00, 1'b0);
    send_fields(KIND_PRG, 16'h0000, 8'h00, 1'b0);

    // Random traffic with one long result stall and one full drain part way through.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 400) begin
        recv_hold  = HOLD_CYCLES;
        send_burst = 80;
      end
      if (i == 800) wait_all_mapped();
      send_request(random_request(1'b0));
    end
    wait_all_mapped();

    // Locked registers: set the lock, then keep trying to load them.
    send_fields(KIND_WRITE, {WINDOW_NIBBLE, 10'($urandom), 2'd3},
                8'h80 | 8'($urandom_range(0, 127)), 1'b0);
    for (int i = 0; i < LOCKED_REQUESTS; i++) send_request(random_request(1'b1));
    wait_all_mapped();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (bank_maps.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
